>>> hw/rtl/glyph_coverage_alpha_compositor_assert.svh
// Assertion macros shared by the compositor RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef GLYPH_COVERAGE_ALPHA_COMPOSITOR_ASSERT_SVH
`define GLYPH_COVERAGE_ALPHA_COMPOSITOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gcac_pkg.sv
// Package for the glyph coverage alpha compositor: codes, types and helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package gcac_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int POS_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int DIM_CALC_W = 14;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 10'd512;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic [1:0] REQ_COMPOSITE = 2'd0;
    localparam logic [1:0] REQ_READ      = 2'd1;
    localparam logic [1:0] REQ_CLEAR     = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FLAG,
        OP_READ,
        OP_WRITE,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [7:0]      alpha;
        logic [2:0][7:0] rgb;
    } item_t;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_LOAD,
        B_WR,
        B_CLR
    } back_state_t;

    // Exact floor(v / 255) for v up to 255 * 255 + 254.
    function automatic logic [7:0] div255(input logic [16:0] v);
        logic [16:0] t;
        t = v + 17'd1 + (v >> 8);
        return t[15:8];
    endfunction

endpackage

>>> hw/rtl/glyph_coverage_alpha_compositor.sv
// Channel   Handshake               Payload
// request   in_valid / in_ready     req_type, pos_x, pos_y, coverage, glyph_color
// result    out_valid / out_ready   pixel_rgba, content_seen
// config    cfg_we                  cfg_index, cfg_data (active_width, active_height)
//
// A skipped composite or a read outside the area is answered from the idle state, a
// read after load, a blended composite after load and write, as set by the single-port
// frame store and one result register. A clear sweeps the active area, one pixel
// written per cycle. After reset the MAX_WIDTH * MAX_HEIGHT store (262144 by default)
// is swept to zero with in_ready low; configuration writes are still taken. A stalled
// result holds the back end; the two-entry queue accepts requests until full.
`timescale 1ns / 1ps

module glyph_coverage_alpha_compositor #(
    parameter int MAX_WIDTH  = gcac_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gcac_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic signed [gcac_pkg::POS_W-1:0]   pos_x,
    input  logic signed [gcac_pkg::POS_W-1:0]   pos_y,
    input  logic [7:0]                          coverage,
    input  logic [31:0]                         glyph_color,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [31:0]                         pixel_rgba,
    output logic                                content_seen,
    input  logic                                cfg_we,
    input  logic [gcac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gcac_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = gcac_pkg::DIM_CALC_W;

    logic [gcac_pkg::CFG_DATA_W-1:0] width_reg;
    logic [gcac_pkg::CFG_DATA_W-1:0] width_next;
    logic [gcac_pkg::CFG_DATA_W-1:0] height_reg;
    logic [gcac_pkg::CFG_DATA_W-1:0] height_next;

    logic [WW-1:0]   eff_w;
    logic [HW-1:0]   eff_h;
    logic            busy;
    logic            q_ready;
    logic            push;
    gcac_pkg::item_t push_item;
    logic [AW-1:0]   push_addr;
    logic            pop;
    logic            q_valid;
    gcac_pkg::item_t q_item;
    logic [AW-1:0]   q_addr;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we && cfg_index == gcac_pkg::CFG_WIDTH)
        begin
            width_next = cfg_data;
        end
        if (cfg_we && cfg_index == gcac_pkg::CFG_HEIGHT)
        begin
            height_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gcac_pkg::DIM_RESET;
            height_reg <= gcac_pkg::DIM_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Register values beyond the store dimensions saturate.
    assign eff_w = (CW'(width_reg) > CW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_reg);
    assign eff_h = (CW'(height_reg) > CW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_reg);

    gcac_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .coverage    (coverage),
        .glyph_color (glyph_color),
        .eff_w       (eff_w),
        .eff_h       (eff_h),
        .busy        (busy),
        .q_ready     (q_ready),
        .push        (push),
        .item        (push_item),
        .addr        (push_addr)
    );

    gcac_queue #(
        .AW (AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .push_addr (push_addr),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_addr    (q_addr)
    );

    gcac_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .eff_w        (eff_w),
        .eff_h        (eff_h),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_addr       (q_addr),
        .pop          (pop),
        .init_busy    (busy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_rgba   (pixel_rgba),
        .content_seen (content_seen)
    );

endmodule

>>> hw/rtl/gcac_front.sv
// Front end: accepts requests, clips positions, derives alpha and the store address.
// Depends on gcac_pkg.
`timescale 1ns / 1ps

module gcac_front #(
    parameter int MAX_WIDTH  = gcac_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gcac_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [1:0]                                      req_type,
    input  logic signed [gcac_pkg::POS_W-1:0]               pos_x,
    input  logic signed [gcac_pkg::POS_W-1:0]               pos_y,
    input  logic [7:0]                                      coverage,
    input  logic [31:0]                                     glyph_color,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]                  eff_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]                 eff_h,
    input  logic                                            busy,
    input  logic                                            q_ready,
    output logic                                            push,
    output gcac_pkg::item_t                                 item,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]         addr
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CW = gcac_pkg::DIM_CALC_W;

    logic [7:0]  opacity;
    logic [15:0] alpha_prod;
    logic [7:0]  alpha;
    logic        x_in;
    logic        y_in;
    logic        in_area;

    assign in_ready = q_ready && !busy;
    assign push     = in_valid && in_ready;

    assign opacity    = 8'hFF - glyph_color[7:0];
    assign alpha_prod = coverage * opacity;
    assign alpha      = alpha_prod[15:8];

    assign x_in    = !pos_x[gcac_pkg::POS_W-1]
                     && (CW'(pos_x[gcac_pkg::POS_W-2:0]) < CW'(eff_w));
    assign y_in    = !pos_y[gcac_pkg::POS_W-1]
                     && (CW'(pos_y[gcac_pkg::POS_W-2:0]) < CW'(eff_h));
    assign in_area = x_in && y_in;

    assign addr = AW'(AW'(pos_y[YW-1:0]) * AW'(MAX_WIDTH)) + AW'(pos_x[XW-1:0]);

    always_comb
    begin
        item.alpha = alpha;
        item.rgb   = glyph_color[31:8];
        case (req_type)
            gcac_pkg::REQ_COMPOSITE:
            begin
                item.op = (in_area && (alpha != 8'd0)) ? gcac_pkg::OP_WRITE
                                                       : gcac_pkg::OP_FLAG;
            end
            gcac_pkg::REQ_READ:
            begin
                item.op = in_area ? gcac_pkg::OP_READ : gcac_pkg::OP_NONE;
            end
            gcac_pkg::REQ_CLEAR:
            begin
                item.op = gcac_pkg::OP_CLEAR;
            end
            default:
            begin
                item.op = gcac_pkg::OP_NONE;
            end
        endcase
    end

endmodule

>>> hw/rtl/gcac_queue.sv
// Short request queue between the front end and the back end.
// Depends on gcac_pkg.
`timescale 1ns / 1ps

module gcac_queue #(
    parameter int AW = 18
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gcac_pkg::item_t push_item,
    input  logic [AW-1:0]   push_addr,
    output logic            q_ready,
    input  logic            pop,
    output logic            q_valid,
    output gcac_pkg::item_t q_item,
    output logic [AW-1:0]   q_addr
);

    localparam int DEPTH = gcac_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    gcac_pkg::item_t item_mem [DEPTH];
    logic [AW-1:0]   addr_mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;

    assign q_ready = (count_reg != NW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = item_mem[rd_ptr_reg];
    assign q_addr  = addr_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_mem[wr_ptr_reg] <= push_item;
            addr_mem[wr_ptr_reg] <= push_addr;
        end
    end

endmodule

>>> hw/rtl/gcac_back.sv
// Back end: frame store, read-modify-write blending, clear sweeps and the result register.
// Depends on gcac_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "glyph_coverage_alpha_compositor_assert.svh"

module gcac_back #(
    parameter int MAX_WIDTH  = gcac_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gcac_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]          eff_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]         eff_h,
    input  logic                                    q_valid,
    input  gcac_pkg::item_t                         q_item,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] q_addr,
    output logic                                    pop,
    output logic                                    init_busy,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [31:0]                             pixel_rgba,
    output logic                                    content_seen
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);

    logic [31:0] mem [DEPTH];

    gcac_pkg::back_state_t state_reg;
    gcac_pkg::back_state_t state_next;

    gcac_pkg::item_t  cur_reg;
    gcac_pkg::item_t  cur_next;
    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    addr_next;
    logic [AW-1:0]    row_base_reg;
    logic [AW-1:0]    row_base_next;
    logic [WW-1:0]    clr_x_reg;
    logic [WW-1:0]    clr_x_next;
    logic [HW-1:0]    clr_y_reg;
    logic [HW-1:0]    clr_y_next;
    logic [31:0]      rd_data_reg;
    logic [2:0][15:0] prod_fg_reg;
    logic [2:0][15:0] prod_fg_next;
    logic [2:0][15:0] prod_bg_reg;
    logic [2:0][15:0] prod_bg_next;
    logic [15:0]      prod_a_reg;
    logic [15:0]      prod_a_next;
    logic             da_nz_reg;
    logic             da_nz_next;
    logic             flag_reg;
    logic             flag_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [31:0]      pixel_reg;
    logic [31:0]      pixel_next;
    logic             has_reg;
    logic             has_next;

    logic             mem_we;
    logic             mem_re;
    logic [31:0]      mem_wdata;
    logic             area_empty;
    logic [WW-1:0]    last_x;
    logic [HW-1:0]    last_y;
    logic             row_done;
    logic             clr_done;
    logic [7:0]       inv;
    logic [2:0][7:0]  blend_rgb;
    logic [7:0]       blend_a;

    assign init_busy    = (state_reg == gcac_pkg::B_INIT);
    assign out_valid    = out_valid_reg;
    assign pixel_rgba   = pixel_reg;
    assign content_seen = has_reg;

    assign area_empty = (eff_w == '0) || (eff_h == '0);
    assign last_x     = eff_w - WW'(1);
    assign last_y     = eff_h - HW'(1);
    assign row_done   = (clr_x_reg == last_x);
    assign clr_done   = row_done && (clr_y_reg == last_y);
    assign inv        = 8'hFF - cur_reg.alpha;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            blend_rgb[c] = da_nz_reg
                ? gcac_pkg::div255(17'(prod_fg_reg[c]) + 17'(prod_bg_reg[c]))
                : cur_reg.rgb[c];
        end
        blend_a = da_nz_reg ? cur_reg.alpha + gcac_pkg::div255(17'(prod_a_reg))
                            : cur_reg.alpha;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gcac_pkg::B_INIT:
            begin
                if (addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = gcac_pkg::B_IDLE;
                end
            end
            gcac_pkg::B_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    if (q_item.op == gcac_pkg::OP_READ || q_item.op == gcac_pkg::OP_WRITE)
                    begin
                        state_next = gcac_pkg::B_LOAD;
                    end
                    else if (q_item.op == gcac_pkg::OP_CLEAR && !area_empty)
                    begin
                        state_next = gcac_pkg::B_CLR;
                    end
                end
            end
            gcac_pkg::B_LOAD:
            begin
                state_next = (cur_reg.op == gcac_pkg::OP_WRITE) ? gcac_pkg::B_WR
                                                                : gcac_pkg::B_IDLE;
            end
            gcac_pkg::B_WR:
            begin
                state_next = gcac_pkg::B_IDLE;
            end
            gcac_pkg::B_CLR:
            begin
                if (clr_done)
                begin
                    state_next = gcac_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = gcac_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        addr_next      = addr_reg;
        row_base_next  = row_base_reg;
        clr_x_next     = clr_x_reg;
        clr_y_next     = clr_y_reg;
        prod_fg_next   = prod_fg_reg;
        prod_bg_next   = prod_bg_reg;
        prod_a_next    = prod_a_reg;
        da_nz_next     = da_nz_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pixel_next     = pixel_reg;
        has_next       = has_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = '0;
        case (state_reg)
            gcac_pkg::B_INIT:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + AW'(1);
            end
            gcac_pkg::B_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    pop       = 1'b1;
                    cur_next  = q_item;
                    addr_next = q_addr;
                    case (q_item.op)
                        gcac_pkg::OP_READ, gcac_pkg::OP_WRITE:
                        begin
                            mem_re = 1'b1;
                        end
                        gcac_pkg::OP_FLAG:
                        begin
                            flag_next      = 1'b1;
                            out_valid_next = 1'b1;
                            pixel_next     = '0;
                            has_next       = 1'b1;
                        end
                        gcac_pkg::OP_CLEAR:
                        begin
                            addr_next     = '0;
                            row_base_next = '0;
                            clr_x_next    = '0;
                            clr_y_next    = '0;
                            if (area_empty)
                            begin
                                flag_next      = 1'b0;
                                out_valid_next = 1'b1;
                                pixel_next     = '0;
                                has_next       = 1'b0;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            pixel_next     = '0;
                            has_next       = flag_reg;
                        end
                    endcase
                end
            end
            gcac_pkg::B_LOAD:
            begin
                if (cur_reg.op == gcac_pkg::OP_WRITE)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        prod_fg_next[c] = cur_reg.alpha * cur_reg.rgb[c];
                        prod_bg_next[c] = inv * rd_data_reg[8*c+8 +: 8];
                    end
                    prod_a_next = inv * rd_data_reg[7:0];
                    da_nz_next  = (rd_data_reg[7:0] != 8'd0);
                end
                else
                begin
                    out_valid_next = 1'b1;
                    pixel_next     = rd_data_reg;
                    has_next       = flag_reg;
                end
            end
            gcac_pkg::B_WR:
            begin
                mem_we         = 1'b1;
                mem_wdata      = {blend_rgb, blend_a};
                flag_next      = 1'b1;
                out_valid_next = 1'b1;
                pixel_next     = '0;
                has_next       = 1'b1;
            end
            gcac_pkg::B_CLR:
            begin
                mem_we = 1'b1;
                if (row_done)
                begin
                    clr_x_next    = '0;
                    clr_y_next    = clr_y_reg + HW'(1);
                    row_base_next = row_base_reg + AW'(MAX_WIDTH);
                    addr_next     = row_base_reg + AW'(MAX_WIDTH);
                end
                else
                begin
                    clr_x_next = clr_x_reg + WW'(1);
                    addr_next  = addr_reg + AW'(1);
                end
                if (clr_done)
                begin
                    flag_next      = 1'b0;
                    out_valid_next = 1'b1;
                    pixel_next     = '0;
                    has_next       = 1'b0;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gcac_pkg::B_INIT;
            addr_reg      <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        row_base_reg <= row_base_next;
        clr_x_reg    <= clr_x_next;
        clr_y_reg    <= clr_y_next;
        prod_fg_reg  <= prod_fg_next;
        prod_bg_reg  <= prod_bg_next;
        prod_a_reg   <= prod_a_next;
        da_nz_reg    <= da_nz_next;
        pixel_reg    <= pixel_next;
        has_reg      <= has_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[q_addr];
        end
    end

    `GCAC_ASSERT_SAME(a_pop_needs_free_out, pop, !out_valid_reg,
        "Request taken while a result is still pending.")
    `GCAC_ASSERT_SAME(a_no_pop_in_init, state_reg == gcac_pkg::B_INIT, !pop,
        "Request taken during the power-up store sweep.")
    `GCAC_ASSERT_NEXT(a_load_then_write,
        state_reg == gcac_pkg::B_LOAD && cur_reg.op == gcac_pkg::OP_WRITE,
        state_reg == gcac_pkg::B_WR && mem_we,
        "Blend load was not followed by its store write.")
    `GCAC_ASSERT_SAME(a_clear_writes_zero, state_reg == gcac_pkg::B_CLR,
        mem_we && mem_wdata == 32'd0,
        "Clear sweep wrote a nonzero pixel.")

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for glyph_coverage_alpha_compositor.
// Drives composite, read and clear requests over several frame sizes and checks
// every reply against a mirror of the frame store; depends on gcac_pkg and the compositor.
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0]                     REQ_UNUSED   = 2'd3;
    localparam logic [gcac_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [gcac_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int MIRROR_DEPTH = gcac_pkg::MAX_WIDTH_DEF * gcac_pkg::MAX_HEIGHT_DEF;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [1:0]                        kind;
        logic signed [gcac_pkg::POS_W-1:0] x;
        logic signed [gcac_pkg::POS_W-1:0] y;
        logic [7:0]                        cov;
        logic [31:0]                       color;
    } glyph_req_t;

    typedef struct {
        logic [31:0] rgba;
        logic        flag;
    } pixel_answer_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [1:0]                         req_type = gcac_pkg::REQ_COMPOSITE;
    logic signed [gcac_pkg::POS_W-1:0]  pos_x = '0;
    logic signed [gcac_pkg::POS_W-1:0]  pos_y = '0;
    logic [7:0]                         coverage = '0;
    logic [31:0]                        glyph_color = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [31:0]                        pixel_rgba;
    logic                               content_seen;
    logic                               cfg_we = 1'b0;
    logic [gcac_pkg::CFG_IDX_W-1:0]     cfg_index = gcac_pkg::CFG_WIDTH;
    logic [gcac_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

    glyph_req_t    request_backlog[$];
    pixel_answer_t pixel_answers[$];

    logic [31:0]                     frame_mirror [0:MIRROR_DEPTH-1];
    logic                            content_mirror = 1'b0;
    logic [gcac_pkg::CFG_DATA_W-1:0] width_mirror = gcac_pkg::DIM_RESET;
    logic [gcac_pkg::CFG_DATA_W-1:0] height_mirror = gcac_pkg::DIM_RESET;

    int  sent_total = 0;
    int  checked_total = 0;
    int  fail_count = 0;
    int  composite_count = 0;
    int  read_count = 0;
    int  clear_count = 0;
    int  setting_count = 0;
    int  send_gap = 0;
    int  stall_gap = 0;
    bit  steady_tail = 1'b0;

    glyph_coverage_alpha_compositor DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .coverage(coverage),
        .glyph_color(glyph_color),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pixel_rgba(pixel_rgba),
        .content_seen(content_seen),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int active_span(input logic [gcac_pkg::CFG_DATA_W-1:0] reg_val,
                                       input int limit);
        return (reg_val > limit) ? limit : int'(reg_val);
    endfunction

    function automatic pixel_answer_t predict_request(input glyph_req_t rq);
        pixel_answer_t ans;
        int w_eff, h_eff, xs, ys, addr;
        int r, g, b, alpha, inv, dr, dg, db, da, cov_i, tt;
        bit in_area;
        logic [31:0] px;
        w_eff = active_span(width_mirror, gcac_pkg::MAX_WIDTH_DEF);
        h_eff = active_span(height_mirror, gcac_pkg::MAX_HEIGHT_DEF);
        xs = rq.x;
        ys = rq.y;
        in_area = (xs >= 0 && ys >= 0 && xs < w_eff && ys < h_eff);
        addr = ys * gcac_pkg::MAX_WIDTH_DEF + xs;
        ans.rgba = '0;
        case (rq.kind)
            gcac_pkg::REQ_COMPOSITE:
            begin
                composite_count++;
                r = rq.color[31:24];
                g = rq.color[23:16];
                b = rq.color[15:8];
                tt = rq.color[7:0];
                cov_i = rq.cov;
                alpha = (cov_i * (255 - tt)) >> 8;
                content_mirror = 1'b1;
                if (in_area && alpha != 0)
                begin
                    px = frame_mirror[addr];
                    dr = px[31:24];
                    dg = px[23:16];
                    db = px[15:8];
                    da = px[7:0];
                    if (da != 0)
                    begin
                        inv = 255 - alpha;
                        r = (alpha * r + inv * dr) / 255;
                        g = (alpha * g + inv * dg) / 255;
                        b = (alpha * b + inv * db) / 255;
                        alpha = alpha + (inv * da) / 255;
                    end
                    frame_mirror[addr] = {r[7:0], g[7:0], b[7:0], alpha[7:0]};
                end
            end
            gcac_pkg::REQ_READ:
            begin
                read_count++;
                if (in_area)
                    ans.rgba = frame_mirror[addr];
            end
            gcac_pkg::REQ_CLEAR:
            begin
                clear_count++;
                for (int yy = 0; yy < h_eff; yy++)
                    for (int xx = 0; xx < w_eff; xx++)
                        frame_mirror[yy * gcac_pkg::MAX_WIDTH_DEF + xx] = '0;
                content_mirror = 1'b0;
            end
            default:
            begin
            end
        endcase
        ans.flag = content_mirror;
        return ans;
    endfunction

    // Request driver: holds each request until it is accepted, then may idle for a burst.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        glyph_req_t nxt;
        glyph_req_t taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                taken.kind = req_type;
                taken.x = pos_x;
                taken.y = pos_y;
                taken.cov = coverage;
                taken.color = glyph_color;
                pixel_answers.push_back(predict_request(taken));
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (request_backlog.size() > 0)
                begin
                    nxt = request_backlog.pop_front();
                    req_type <= nxt.kind;
                    pos_x <= nxt.x;
                    pos_y <= nxt.y;
                    coverage <= nxt.cov;
                    glyph_color <= nxt.color;
                    in_valid <= 1'b1;
                    if (!steady_tail && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 16);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : reply_monitor
        pixel_answer_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                checked_total++;
                if (pixel_answers.size() == 0)
                begin
                    $error("reply with no request waiting: pixel_rgba %h content_seen %b",
                           pixel_rgba, content_seen);
                    fail_count++;
                end
                else
                begin
                    want = pixel_answers.pop_front();
                    if (pixel_rgba !== want.rgba)
                    begin
                        $error("pixel_rgba expected %h actual %h", want.rgba, pixel_rgba);
                        fail_count++;
                    end
                    if (content_seen !== want.flag)
                    begin
                        $error("content_seen expected %b actual %b", want.flag, content_seen);
                        fail_count++;
                    end
                end
            end
            if (stall_gap > 0)
            begin
                stall_gap--;
                out_ready <= 1'b0;
            end
            else if (!steady_tail && $urandom_range(0, 11) == 0)
            begin
                stall_gap = $urandom_range(1, 16) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_dim(input logic [gcac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gcac_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == gcac_pkg::CFG_WIDTH)
            width_mirror = val;
        else if (idx == gcac_pkg::CFG_HEIGHT)
            height_mirror = val;
    endtask

    task automatic queue_request(input logic [1:0] kind, input int x, input int y,
                                 input int cov, input logic [31:0] color);
        glyph_req_t rq;
        rq.kind = kind;
        rq.x = x[gcac_pkg::POS_W-1:0];
        rq.y = y[gcac_pkg::POS_W-1:0];
        rq.cov = cov[7:0];
        rq.color = color;
        request_backlog.push_back(rq);
        sent_total++;
    endtask

    task automatic settle();
        while (checked_total != sent_total)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int near_edge(input int span);
        if (span <= 16)
            return $urandom_range(0, span - 1);
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 15);
        return $urandom_range(span - 16, span - 1);
    endfunction

    task automatic queue_random(input int count);
        int pick, w_eff, h_eff, xs, ys;
        logic [1:0] kind;
        w_eff = active_span(width_mirror, gcac_pkg::MAX_WIDTH_DEF);
        h_eff = active_span(height_mirror, gcac_pkg::MAX_HEIGHT_DEF);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4 && w_eff * h_eff <= 4096)
                kind = gcac_pkg::REQ_CLEAR;
            else if (pick < 7)
                kind = REQ_UNUSED;
            else if (pick < 30)
                kind = gcac_pkg::REQ_READ;
            else
                kind = gcac_pkg::REQ_COMPOSITE;
            if (w_eff == 0 || h_eff == 0 || $urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: xs = $urandom_range(0, 8191);
                    1: xs = w_eff;
                    default: xs = -1;
                endcase
                ys = $urandom_range(0, 8191);
            end
            else
            begin
                xs = near_edge(w_eff);
                ys = near_edge(h_eff);
            end
            queue_request(kind, xs, ys, $urandom_range(0, 255), $urandom());
        end
    endtask

    initial
    begin : stimulus
        int rand_w [7] = '{8, 1, 1023, 3, 37, 0, 16};
        int rand_h [7] = '{4, 1, 2, 512, 23, 7, 16};
        int rand_n [7] = '{150, 60, 150, 150, 200, 30, 180};
        for (int i = 0; i < MIRROR_DEPTH; i++)
            frame_mirror[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        write_dim(gcac_pkg::CFG_WIDTH, 10'd1023);
        write_dim(gcac_pkg::CFG_HEIGHT, 10'd1023);
        setting_count++;
        queue_request(gcac_pkg::REQ_READ, 0, 0, 0, 32'h0);
        queue_request(gcac_pkg::REQ_COMPOSITE, 0, 0, 255, 32'hFF804000);
        queue_request(gcac_pkg::REQ_COMPOSITE, 0, 0, 128, 32'h10203040);
        queue_request(gcac_pkg::REQ_READ, 0, 0, 0, 32'h0);
        queue_request(gcac_pkg::REQ_COMPOSITE, 511, 511, 255, 32'hFFFFFF00);
        queue_request(gcac_pkg::REQ_READ, 511, 511, 0, 32'h0);
        queue_request(gcac_pkg::REQ_COMPOSITE, 512, 0, 255, 32'h12345600);
        queue_request(gcac_pkg::REQ_COMPOSITE, -1, 5, 255, 32'h12345600);
        queue_request(gcac_pkg::REQ_COMPOSITE, -4096, 4095, 255, 32'h00000000);
        queue_request(gcac_pkg::REQ_COMPOSITE, 1, 0, 0, 32'hFFFFFFFF);
        queue_request(gcac_pkg::REQ_COMPOSITE, 1, 0, 255, 32'hFFFFFFFF);
        queue_request(gcac_pkg::REQ_COMPOSITE, 1, 0, 1, 32'h00000000);
        queue_request(gcac_pkg::REQ_COMPOSITE, 1, 0, 2, 32'h00000000);
        queue_request(gcac_pkg::REQ_READ, 1, 0, 0, 32'h0);
        queue_request(gcac_pkg::REQ_READ, 4095, -4096, 255, 32'hFFFFFFFF);
        queue_request(REQ_UNUSED, 7, 7, 8'hAA, 32'hDEADBEEF);
        queue_request(gcac_pkg::REQ_CLEAR, 0, 0, 0, 32'h0);
        queue_request(gcac_pkg::REQ_READ, 0, 0, 0, 32'h0);
        queue_request(gcac_pkg::REQ_READ, 511, 511, 0, 32'h0);
        queue_request(gcac_pkg::REQ_COMPOSITE, 20, 20, 200, 32'h80C0E010);
        queue_request(gcac_pkg::REQ_COMPOSITE, 3, 3, 255, 32'h01020304);
        settle();

        // The spare register indexes must not disturb the frame size.
        write_dim(gcac_pkg::CFG_WIDTH, 10'd16);
        write_dim(gcac_pkg::CFG_HEIGHT, 10'd16);
        write_dim(CFG_SPARE_LO, 10'd3);
        write_dim(CFG_SPARE_HI, 10'd700);
        setting_count++;
        queue_request(gcac_pkg::REQ_CLEAR, 0, 0, 0, 32'h0);
        queue_request(gcac_pkg::REQ_READ, 3, 3, 0, 32'h0);
        queue_request(gcac_pkg::REQ_READ, 20, 20, 0, 32'h0);
        queue_request(gcac_pkg::REQ_COMPOSITE, 15, 15, 255, 32'hA0B0C000);
        settle();

        write_dim(gcac_pkg::CFG_WIDTH, 10'd0);
        write_dim(gcac_pkg::CFG_HEIGHT, 10'd5);
        setting_count++;
        queue_request(gcac_pkg::REQ_COMPOSITE, 0, 0, 255, 32'h11223300);
        queue_request(gcac_pkg::REQ_READ, 0, 0, 0, 32'h0);
        queue_request(gcac_pkg::REQ_CLEAR, 0, 0, 0, 32'h0);
        queue_request(gcac_pkg::REQ_READ, 15, 15, 0, 32'h0);
        settle();

        // Pixels left outside the shrunken area must survive the earlier clears.
        write_dim(gcac_pkg::CFG_WIDTH, 10'd513);
        write_dim(gcac_pkg::CFG_HEIGHT, 10'd600);
        setting_count++;
        queue_request(gcac_pkg::REQ_READ, 20, 20, 0, 32'h0);
        queue_request(gcac_pkg::REQ_READ, 15, 15, 0, 32'h0);
        queue_request(gcac_pkg::REQ_READ, 511, 0, 0, 32'h0);
        settle();

        for (int p = 0; p < 7; p++)
        begin
            write_dim(gcac_pkg::CFG_WIDTH, rand_w[p][gcac_pkg::CFG_DATA_W-1:0]);
            write_dim(gcac_pkg::CFG_HEIGHT, rand_h[p][gcac_pkg::CFG_DATA_W-1:0]);
            setting_count++;
            if (p == 6)
                steady_tail = 1'b1;
            queue_random(rand_n[p]);
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pixel_answers.size() != 0)
        begin
            $error("%0d replies never arrived", pixel_answers.size());
            fail_count++;
        end
        $display("Covered %0d requests under %0d frame settings, from empty to full size.",
                 sent_total, setting_count);
        $display("Request mix: %0d composites, %0d reads, %0d clears.",
                 composite_count, read_count, clear_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> glyph_coverage_alpha_compositor.f
+incdir+hw/rtl
hw/rtl/gcac_pkg.sv
hw/rtl/gcac_front.sv
hw/rtl/gcac_queue.sv
hw/rtl/gcac_back.sv
hw/rtl/glyph_coverage_alpha_compositor.sv
tb/sv/tb.sv
